// ===== rtl/awbgw_pkg.sv =====
// awbgw_pkg: shared types and constants for the AWB channel gain writer.
// Depends on nothing.
package awbgw_pkg;

	localparam int unsigned UNITY_REL  = 1000;
	localparam logic [15:0] UNITY_GAIN = 16'h0400;
	localparam logic [15:0] ADDR_R     = 16'h5104;
	localparam logic [15:0] ADDR_G     = 16'h5102;
	localparam logic [15:0] ADDR_B     = 16'h5100;
	localparam logic [15:0] GAIN_MAX   = 16'hFFFF;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_DONE  = 1'b1;

	// relative gains fit in 26 bits (65535*1000)
	localparam int REL_W = 26;
	// 1024*rel needs 36 bits
	localparam int NUM_W = 36;

	// job handed from front to back
	typedef struct packed {
		logic             reject;
		logic [REL_W-1:0] rel_r;
		logic [REL_W-1:0] rel_b;
		logic [REL_W-1:0] base;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DIV, ST_EMIT_HI, ST_EMIT_LO, ST_DONE
	} bk_state_t;

	typedef enum logic [1:0] {
		FR_IDLE, FR_DIV_R, FR_DIV_B, FR_SEND
	} fr_state_t;

endpackage

// ===== rtl/awbgw_div.sv =====
// awbgw_div: restoring divider, one quotient bit per cycle.
// Depends on awbgw_pkg.
module awbgw_div
	import awbgw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [REL_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	logic [NUM_W-1:0] quo_q;
	logic [REL_W:0]   rem_q;
	logic [REL_W-1:0] den_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [REL_W:0]   shifted;
	logic [REL_W:0]   diff;

	assign shifted = {rem_q[REL_W-1:0], quo_q[NUM_W-1]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[REL_W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;
endmodule

// ===== rtl/awbgw_front.sv =====
// awbgw_front: accepts ratios, forms relative gains and the base.
// Depends on awbgw_pkg and awbgw_div.
module awbgw_front
	import awbgw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] measured_rg,
	input  logic [15:0] measured_bg,
	input  logic [15:0] golden_rg,
	input  logic [15:0] golden_bg,
	output logic        job_valid,
	input  logic        job_ready,
	output job_t        job
);
	fr_state_t        state_q, state_d;
	logic [15:0]      mbg_q, gbg_q;
	logic [REL_W-1:0] rel_r_q, rel_b_q;
	logic             reject_q;
	logic             dv_start;
	logic [NUM_W-1:0] dv_num;
	logic [REL_W-1:0] dv_den;
	logic             dv_busy, dv_done;
	logic [NUM_W-1:0] dv_quo;
	logic             acc;
	logic             zero_in;
	logic [REL_W-1:0] base;

	assign acc     = push && !full;
	assign zero_in = (measured_rg == 16'd0) || (measured_bg == 16'd0) ||
		(golden_rg == 16'd0) || (golden_bg == 16'd0);

	awbgw_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .num(dv_num), .den(dv_den),
		.busy(dv_busy), .done(dv_done), .quo(dv_quo)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			FR_IDLE:  if (acc) state_d = zero_in ? FR_SEND : FR_DIV_R;
			FR_DIV_R: if (dv_done) state_d = FR_DIV_B;
			FR_DIV_B: if (dv_done && !dv_start) state_d = FR_SEND;
			FR_SEND:  if (job_ready) state_d = FR_IDLE;
			default:  state_d = FR_IDLE;
		endcase
	end

	always_comb begin
		full     = (state_q != FR_IDLE);
		dv_start = 1'b0;
		dv_num   = 36'(golden_rg) * 36'(UNITY_REL);
		dv_den   = REL_W'(measured_rg);
		if (state_q == FR_IDLE && acc && !zero_in) begin
			dv_start = 1'b1;
		end else if (state_q == FR_DIV_R && dv_done) begin
			dv_start = 1'b1;
			dv_num   = 36'(gbg_q) * 36'(UNITY_REL);
			dv_den   = REL_W'(mbg_q);
		end
		job_valid = (state_q == FR_SEND);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FR_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (state_q == FR_IDLE && acc) begin
			mbg_q    <= measured_bg;
			gbg_q    <= golden_bg;
			reject_q <= zero_in;
		end
		if (state_q == FR_DIV_R && dv_done) rel_r_q <= REL_W'(dv_quo);
		if (state_q == FR_DIV_B && dv_done) rel_b_q <= REL_W'(dv_quo);
	end

	always_comb begin
		if (rel_r_q < REL_W'(UNITY_REL) || rel_b_q < REL_W'(UNITY_REL))
			base = (rel_r_q < rel_b_q) ? rel_r_q : rel_b_q;
		else
			base = REL_W'(UNITY_REL);
		job.rel_r  = rel_r_q;
		job.rel_b  = rel_b_q;
		job.base   = base;
		job.reject = reject_q || (base == '0);
	end

	logic unused_busy;
	assign unused_busy = dv_busy;
endmodule

// ===== rtl/awbgw_back.sv =====
// awbgw_back: forms the three gains and emits register write words.
// Depends on awbgw_pkg and awbgw_div.
module awbgw_back
	import awbgw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	output logic        job_ready,
	input  job_t        job,
	output logic        empty,
	input  logic        pop,
	output logic        result_kind,
	output logic [15:0] reg_addr,
	output logic [7:0]  reg_data,
	output logic        status,
	output logic        last
);
	bk_state_t        state_q, state_d;
	job_t             job_q;
	job_t             cur_job;
	logic [1:0]       ch_q;
	logic [1:0]       div_ch;
	logic [15:0]      gain_q;
	logic             dv_start, dv_busy, dv_done;
	logic [NUM_W-1:0] dv_quo;
	logic [REL_W-1:0] rel;
	logic [15:0]      addr;
	logic             take;

	assign take = pop && !empty;

	// first division reads the job straight from the front, later ones the held copy
	assign cur_job = (state_q == ST_IDLE) ? job : job_q;
	// channel of the division being started: R from idle, else the one after ch_q
	assign div_ch  = (state_q == ST_IDLE) ? 2'd0 : ch_q + 2'd1;

	always_comb begin
		case (div_ch)
			2'd0:    rel = cur_job.rel_r;
			2'd1:    rel = REL_W'(UNITY_REL);
			default: rel = cur_job.rel_b;
		endcase
		case (ch_q)
			2'd0:    addr = ADDR_R;
			2'd1:    addr = ADDR_G;
			default: addr = ADDR_B;
		endcase
	end

	awbgw_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start),
		.num({rel, 10'd0}), .den(cur_job.base),
		.busy(dv_busy), .done(dv_done), .quo(dv_quo)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (job_valid) state_d = job.reject ? ST_DONE : ST_DIV;
			ST_DIV:     if (dv_done) begin
				if (dv_quo > NUM_W'(UNITY_GAIN)) state_d = ST_EMIT_HI;
				else if (ch_q == 2'd2) state_d = ST_DONE;
			end
			ST_EMIT_HI: if (take) state_d = ST_EMIT_LO;
			ST_EMIT_LO: if (take) state_d = (ch_q == 2'd2) ? ST_DONE : ST_DIV;
			ST_DONE:    if (take) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		job_ready   = (state_q == ST_IDLE);
		dv_start    = ((state_q == ST_IDLE) && job_valid && !job.reject) ||
			((state_q == ST_DIV) && dv_done && !(dv_quo > NUM_W'(UNITY_GAIN)) &&
			 ch_q != 2'd2) ||
			((state_q == ST_EMIT_LO) && take && ch_q != 2'd2);
		empty       = !(state_q == ST_EMIT_HI || state_q == ST_EMIT_LO ||
			state_q == ST_DONE);
		result_kind = (state_q == ST_DONE) ? KIND_DONE : KIND_WRITE;
		last        = (state_q == ST_DONE);
		status      = (state_q == ST_DONE) && job_q.reject;
		reg_addr    = 16'd0;
		reg_data    = 8'd0;
		if (state_q == ST_EMIT_HI) begin
			reg_addr = addr;
			reg_data = gain_q[15:8];
		end else if (state_q == ST_EMIT_LO) begin
			reg_addr = addr + 16'd1;
			reg_data = gain_q[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= 2'd0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) ch_q <= 2'd0;
			else if (dv_start) ch_q <= ch_q + 2'd1;
		end
	end

	// job held for the later divisions and for the completion status
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && job_valid) job_q <= job;
		if (state_q == ST_DIV && dv_done)
			gain_q <= (dv_quo > NUM_W'(GAIN_MAX)) ? GAIN_MAX : dv_quo[15:0];
	end

	logic unused_busy;
	assign unused_busy = dv_busy;
endmodule

// ===== rtl/awb_channel_gain_writer.sv =====
// awb_channel_gain_writer: top level, front (ratios) and back (gain writes).
// Depends on awbgw_pkg, awbgw_front, awbgw_back, awbgw_div.
//
//  channel | handshake     | words
//  input   | push / full   | measured_rg, measured_bg, golden_rg, golden_bg
//  result  | empty / pop   | result_kind, reg_addr, reg_data, status, last
//
// Each serial division runs 36 steps and then raises done with the quotient.
// The front runs two (relative R and B, skipped when any input is zero) and
// hands off; new input words are accepted only once that handoff is done. The
// back runs up to three divisions for the gains and emits up to seven words;
// front and back overlap through a one-job holding register. Reset clears all
// control state at once.
// Result stalls hold the back; the front keeps working up to its handoff.
module awb_channel_gain_writer
	import awbgw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] measured_rg,
	input  logic [15:0] measured_bg,
	input  logic [15:0] golden_rg,
	input  logic [15:0] golden_bg,
	output logic        empty,
	input  logic        pop,
	output logic        result_kind,
	output logic [15:0] reg_addr,
	output logic [7:0]  reg_data,
	output logic        status,
	output logic        last
);
	logic job_valid, job_ready;
	job_t job;

	awbgw_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.measured_rg(measured_rg), .measured_bg(measured_bg),
		.golden_rg(golden_rg), .golden_bg(golden_bg),
		.job_valid(job_valid), .job_ready(job_ready), .job(job)
	);

	awbgw_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job_ready(job_ready),
		.job(job), .empty(empty), .pop(pop), .result_kind(result_kind),
		.reg_addr(reg_addr), .reg_data(reg_data), .status(status), .last(last)
	);

`ifndef SYNTHESIS
	// only the completion word is last
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (last == result_kind)) else $error("last/kind mismatch");
	// rejected status only on completion
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status) |-> result_kind) else $error("status on write");
	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(reg_addr) && $stable(reg_data)))
		else $error("result changed under stall");
`endif
endmodule
